### sv/utc_pkg.sv
// Package for the unicycle tracking controller: widths, register map,
// CORDIC constants and fixed-point helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package utc_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CORDIC_STEPS = 24;
    localparam logic signed [63:0] CORDIC_GAIN = 64'sd652032874;
    localparam logic signed [63:0] TURN_SCALE = 64'sd683565276;
    localparam int NUM_REGS = 7;
    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_GAIN_ALONG = 3'd0;
    localparam logic [2:0] REG_GAIN_HEADING = 3'd1;
    localparam logic [2:0] REG_GAIN_LATERAL = 3'd2;
    localparam logic [2:0] REG_SPEED_GAIN = 3'd3;
    localparam logic [2:0] REG_TURN_GAIN = 3'd4;
    localparam logic [2:0] REG_WHEEL_RADIUS = 3'd5;
    localparam logic [2:0] REG_INV_HALF_WIDTH = 3'd6;

    localparam logic [30:0] RST_GAIN_ALONG = 31'd360448;
    localparam logic [30:0] RST_GAIN_LATERAL = 31'd622592;
    localparam logic [30:0] RST_SPEED_GAIN = 31'd163840;
    localparam logic [30:0] RST_TURN_GAIN = 31'd65536;
    localparam logic [30:0] RST_WHEEL_RADIUS = 31'd2392;
    localparam logic [30:0] RST_INV_HALF_WIDTH = 31'd624153;

    typedef struct packed {
        logic [30:0] gain_along;
        logic [30:0] gain_heading;
        logic [30:0] gain_lateral;
        logic [30:0] speed_gain;
        logic [30:0] turn_gain;
        logic [30:0] wheel_radius;
        logic [30:0] inverse_half_width;
    } gains_t;

    function automatic logic [31:0] atan_entry(input int i);
        logic [31:0] r;
        unique case (i)
            0: r = 32'd536870912;
            1: r = 32'd316933406;
            2: r = 32'd167458907;
            3: r = 32'd85004756;
            4: r = 32'd42667331;
            5: r = 32'd21354465;
            6: r = 32'd10679838;
            7: r = 32'd5340245;
            8: r = 32'd2670163;
            9: r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            default: r = 32'd81;
        endcase
        return r;
    endfunction

    function automatic logic [30:0] q16_scale(input logic [30:0] v, input int fb);
        logic [63:0] w;
        w = {33'd0, v} << fb;
        return w[46:16];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction
endpackage
`default_nettype wire

### sv/utc_cfg_regs.sv
// APB register file for the tracking controller gains.
// Depends on utc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module utc_cfg_regs #(
    parameter int FRAC_BITS = utc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [utc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output utc_pkg::gains_t                gains
);
    logic [30:0] regs_reg [utc_pkg::NUM_REGS];
    logic [2:0]  idx;
    logic        wr;

    assign idx = paddr[4:2];
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg[0] <= utc_pkg::q16_scale(utc_pkg::RST_GAIN_ALONG, FRAC_BITS);
            regs_reg[1] <= utc_pkg::q16_scale(utc_pkg::RST_GAIN_ALONG, FRAC_BITS);
            regs_reg[2] <= utc_pkg::q16_scale(utc_pkg::RST_GAIN_LATERAL, FRAC_BITS);
            regs_reg[3] <= utc_pkg::q16_scale(utc_pkg::RST_SPEED_GAIN, FRAC_BITS);
            regs_reg[4] <= utc_pkg::q16_scale(utc_pkg::RST_TURN_GAIN, FRAC_BITS);
            regs_reg[5] <= utc_pkg::q16_scale(utc_pkg::RST_WHEEL_RADIUS, FRAC_BITS);
            regs_reg[6] <= utc_pkg::q16_scale(utc_pkg::RST_INV_HALF_WIDTH, FRAC_BITS);
        end
        else if (wr && idx < 3'(utc_pkg::NUM_REGS))
        begin
            regs_reg[idx] <= pwdata[30:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (idx < 3'(utc_pkg::NUM_REGS))
            prdata = {1'b0, regs_reg[idx]};
    end

    assign gains.gain_along = regs_reg[utc_pkg::REG_GAIN_ALONG];
    assign gains.gain_heading = regs_reg[utc_pkg::REG_GAIN_HEADING];
    assign gains.gain_lateral = regs_reg[utc_pkg::REG_GAIN_LATERAL];
    assign gains.speed_gain = regs_reg[utc_pkg::REG_SPEED_GAIN];
    assign gains.turn_gain = regs_reg[utc_pkg::REG_TURN_GAIN];
    assign gains.wheel_radius = regs_reg[utc_pkg::REG_WHEEL_RADIUS];
    assign gains.inverse_half_width = regs_reg[utc_pkg::REG_INV_HALF_WIDTH];
endmodule
`default_nettype wire

### sv/utc_cordic.sv
// Pipelined sine/cosine: angle scaling to binary angle, quadrant fold,
// one CORDIC iteration per stage. Depends on utc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module utc_cordic #(
    parameter int FRAC_BITS = utc_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic signed [32:0] angle,
    output logic signed [33:0]      cos_out,
    output logic signed [33:0]      sin_out
);
    localparam int N = utc_pkg::CORDIC_STEPS;

    logic signed [65:0] prod_reg;
    logic [31:0]        ph;
    logic               flip;
    logic [31:0]        phf;
    logic signed [33:0] x_reg [N+1];
    logic signed [33:0] y_reg [N+1];
    logic signed [32:0] z_reg [N+1];
    logic               f_reg [N+1];

    always_ff @(posedge clk)
    begin
        prod_reg <= 66'(angle) * 66'(utc_pkg::TURN_SCALE);
    end

    assign ph = 32'(prod_reg >>> FRAC_BITS);
    assign flip = (ph - 32'h40000000) < 32'h80000000;
    assign phf = flip ? ph + 32'h80000000 : ph;

    always_ff @(posedge clk)
    begin
        x_reg[0] <= 34'(utc_pkg::CORDIC_GAIN);
        y_reg[0] <= '0;
        z_reg[0] <= 33'(signed'(phf));
        f_reg[0] <= flip;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (!z_reg[i][32])
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - 33'(utc_pkg::atan_entry(i));
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + 33'(utc_pkg::atan_entry(i));
            end
            f_reg[i+1] <= f_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        cos_out <= f_reg[N] ? -x_reg[N] : x_reg[N];
        sin_out <= f_reg[N] ? -y_reg[N] : y_reg[N];
    end
endmodule
`default_nettype wire

### sv/utc_delay.sv
// Fixed-latency delay line for payload and valid bits.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module utc_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    output logic [WIDTH-1:0]      out_data
);
    logic [WIDTH-1:0] d_reg [DEPTH];
    logic [DEPTH-1:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[DEPTH-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        d_reg[0] <= in_data;
        for (int i = 1; i < DEPTH; i++)
            d_reg[i] <= d_reg[i-1];
    end

    assign out_valid = v_reg[DEPTH-1];
    assign out_data = d_reg[DEPTH-1];
endmodule
`default_nettype wire

### sv/unicycle_tracking_controller.sv
// Unicycle tracking controller: Kanayama outer law, proportional inner loop.
// Throughput: one transaction per cycle; busy is always low, two CORDIC pipes.
// Reset clears the valid bits and loads the gain registers with defaults.
// The receiver cannot stall: done pulses for one cycle with the result.
`timescale 1ns / 1ps
`default_nettype none
module unicycle_tracking_controller #(
    parameter int FRAC_BITS = utc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [utc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic signed [31:0]         ref_x,
    input  wire logic signed [31:0]         ref_y,
    input  wire logic signed [31:0]         ref_heading,
    input  wire logic signed [31:0]         ref_speed,
    input  wire logic signed [31:0]         ref_turn_rate,
    input  wire logic signed [31:0]         pos_x,
    input  wire logic signed [31:0]         pos_y,
    input  wire logic signed [31:0]         heading,
    input  wire logic signed [31:0]         meas_speed,
    input  wire logic signed [31:0]         meas_turn_rate,
    output logic                            done,
    output logic signed [31:0]              left_torque,
    output logic signed [31:0]              right_torque,
    output logic signed [31:0]              desired_speed,
    output logic signed [31:0]              desired_turn_rate
);
    localparam int CL = utc_pkg::CORDIC_STEPS + 3;
    localparam int PW = 32 * 10;

    utc_pkg::gains_t g;

    assign pready = 1'b1;
    assign busy = 1'b0;

    utc_cfg_regs #(.FRAC_BITS(FRAC_BITS)) u_cfg (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .gains(g)
    );

    // stage A: first CORDIC on heading, carry inputs
    logic signed [33:0] c1, s1;
    utc_cordic #(.FRAC_BITS(FRAC_BITS)) u_cs1 (
        .clk, .angle(33'(heading)), .cos_out(c1), .sin_out(s1)
    );

    logic          va;
    logic [PW-1:0] pa;
    utc_delay #(.WIDTH(PW), .DEPTH(CL)) u_da (
        .clk, .rst_n, .in_valid(start),
        .in_data({ref_x, ref_y, ref_heading, ref_speed, ref_turn_rate,
                  pos_x, pos_y, heading, meas_speed, meas_turn_rate}),
        .out_valid(va), .out_data(pa)
    );

    logic signed [31:0] a_rx, a_ry, a_rth, a_rv, a_rw, a_px, a_py, a_th, a_mv, a_mw;
    assign {a_rx, a_ry, a_rth, a_rv, a_rw, a_px, a_py, a_th, a_mv, a_mw} = pa;

    // stage B: products for rotation
    logic signed [32:0] b_dx, b_dy;
    logic signed [66:0] b_cdx_reg, b_sdy_reg, b_cdy_reg, b_sdx_reg;
    logic signed [32:0] b_eth_reg;
    logic               vb_reg;
    logic signed [31:0] b_rv_reg, b_rw_reg, b_mv_reg, b_mw_reg;
    assign b_dx = 33'(a_rx) - 33'(a_px);
    assign b_dy = 33'(a_ry) - 33'(a_py);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else
            vb_reg <= va;
    end

    always_ff @(posedge clk)
    begin
        b_cdx_reg <= 67'(c1) * 67'(b_dx);
        b_sdy_reg <= 67'(s1) * 67'(b_dy);
        b_cdy_reg <= 67'(c1) * 67'(b_dy);
        b_sdx_reg <= 67'(s1) * 67'(b_dx);
        b_eth_reg <= 33'(a_rth) - 33'(a_th);
        b_rv_reg <= a_rv;
        b_rw_reg <= a_rw;
        b_mv_reg <= a_mv;
        b_mw_reg <= a_mw;
    end

    // stage C: errors in robot frame
    logic signed [31:0] c_ex_reg, c_ey_reg;
    logic signed [32:0] c_eth_reg;
    logic               vc_reg;
    logic signed [31:0] c_rv_reg, c_rw_reg, c_mv_reg, c_mw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else
            vc_reg <= vb_reg;
    end

    always_ff @(posedge clk)
    begin
        c_ex_reg <= utc_pkg::sat32(66'((b_cdx_reg >>> 30) + (b_sdy_reg >>> 30)));
        c_ey_reg <= utc_pkg::sat32(66'((b_cdy_reg >>> 30) - (b_sdx_reg >>> 30)));
        c_eth_reg <= b_eth_reg;
        c_rv_reg <= b_rv_reg;
        c_rw_reg <= b_rw_reg;
        c_mv_reg <= b_mv_reg;
        c_mw_reg <= b_mw_reg;
    end

    // second CORDIC on heading error
    logic signed [33:0] c2, s2;
    utc_cordic #(.FRAC_BITS(FRAC_BITS)) u_cs2 (
        .clk, .angle(c_eth_reg), .cos_out(c2), .sin_out(s2)
    );

    logic          vd2;
    logic [191:0]  pd;
    utc_delay #(.WIDTH(192), .DEPTH(CL)) u_dd (
        .clk, .rst_n, .in_valid(vc_reg),
        .in_data({c_ex_reg, c_ey_reg, utc_pkg::sat32(66'(c_eth_reg)),
                  c_rv_reg, c_rw_reg, c_mv_reg ^ 32'd0}),
        .out_valid(vd2), .out_data(pd)
    );
    logic          vmw;
    logic [31:0]   d_mw;
    utc_delay #(.WIDTH(32), .DEPTH(CL)) u_dm (
        .clk, .rst_n, .in_valid(vc_reg), .in_data(c_mw_reg),
        .out_valid(vmw), .out_data(d_mw)
    );
    logic signed [31:0] d_ex, d_ey, d_eth, d_rv, d_rw, d_mv;
    assign {d_ex, d_ey, d_eth, d_rv, d_rw, d_mv} = pd;

    // stage E: outer-law products
    logic signed [66:0] e_rvc_reg;
    logic signed [63:0] e_kx_reg, e_ky_reg, e_kh_reg;
    logic               ve_reg;
    logic signed [31:0] e_rv_reg, e_rw_reg, e_mv_reg, e_mw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ve_reg <= 1'b0;
        else
            ve_reg <= vd2 && vmw;
    end

    always_ff @(posedge clk)
    begin
        e_rvc_reg <= 67'(d_rv) * 67'(c2);
        e_kx_reg <= 64'(signed'({1'b0, g.gain_along})) * 64'(d_ex);
        e_ky_reg <= 64'(signed'({1'b0, g.gain_lateral})) * 64'(d_ey);
        e_kh_reg <= 64'(signed'({1'b0, g.gain_heading})) * 64'(d_eth);
        e_rv_reg <= d_rv;
        e_rw_reg <= d_rw;
        e_mv_reg <= d_mv;
        e_mw_reg <= d_mw;
    end

    // stage F: desired speed and turn rate
    logic signed [65:0] f_lat;
    logic signed [31:0] f_vd_reg, f_wd_reg, f_mv_reg, f_mw_reg;
    logic               vf_reg;
    always_comb
    begin
        f_lat = 66'(e_ky_reg >>> FRAC_BITS);
        if (e_rv_reg < 0)
            f_lat = -f_lat;
        else if (e_rv_reg == 0)
            f_lat = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vf_reg <= 1'b0;
        else
            vf_reg <= ve_reg;
    end

    always_ff @(posedge clk)
    begin
        f_vd_reg <= utc_pkg::sat32(66'(e_rvc_reg >>> 30) + 66'(e_kx_reg >>> FRAC_BITS));
        f_wd_reg <= utc_pkg::sat32(66'(e_rw_reg) + f_lat + 66'(e_kh_reg >>> FRAC_BITS));
        f_mv_reg <= e_mv_reg;
        f_mw_reg <= e_mw_reg;
    end

    // stage G: speed and turn errors
    logic signed [31:0] g_ve_reg, g_we_reg, g_vd_reg, g_wd_reg;
    logic               vg_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vg_reg <= 1'b0;
        else
            vg_reg <= vf_reg;
    end
    always_ff @(posedge clk)
    begin
        g_ve_reg <= utc_pkg::sat32(66'(f_vd_reg) - 66'(f_mv_reg));
        g_we_reg <= utc_pkg::sat32(66'(f_wd_reg) - 66'(f_mw_reg));
        g_vd_reg <= f_vd_reg;
        g_wd_reg <= f_wd_reg;
    end

    // stage H: gain products
    logic signed [63:0] h_f_reg, h_t_reg;
    logic signed [31:0] h_vd_reg, h_wd_reg;
    logic               vh_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vh_reg <= 1'b0;
        else
            vh_reg <= vg_reg;
    end
    always_ff @(posedge clk)
    begin
        h_f_reg <= 64'(signed'({1'b0, g.speed_gain})) * 64'(g_ve_reg);
        h_t_reg <= 64'(signed'({1'b0, g.turn_gain})) * 64'(g_we_reg);
        h_vd_reg <= g_vd_reg;
        h_wd_reg <= g_wd_reg;
    end

    // stage I: saturate force and turn
    logic signed [31:0] i_f_reg, i_t_reg, i_vd_reg, i_wd_reg;
    logic               vi_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vi_reg <= 1'b0;
        else
            vi_reg <= vh_reg;
    end
    always_ff @(posedge clk)
    begin
        i_f_reg <= utc_pkg::sat32(66'(h_f_reg >>> FRAC_BITS));
        i_t_reg <= utc_pkg::sat32(66'(h_t_reg >>> FRAC_BITS));
        i_vd_reg <= h_vd_reg;
        i_wd_reg <= h_wd_reg;
    end

    // stage J: turn times inverse half width
    logic signed [63:0] j_tw_reg;
    logic signed [31:0] j_f_reg, j_vd_reg, j_wd_reg;
    logic               vj_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vj_reg <= 1'b0;
        else
            vj_reg <= vi_reg;
    end
    always_ff @(posedge clk)
    begin
        j_tw_reg <= 64'(signed'({1'b0, g.inverse_half_width})) * 64'(i_t_reg);
        j_f_reg <= i_f_reg;
        j_vd_reg <= i_vd_reg;
        j_wd_reg <= i_wd_reg;
    end

    // stage K: saturate turn term
    logic signed [31:0] k_tw_reg, k_f_reg, k_vd_reg, k_wd_reg;
    logic               vk_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vk_reg <= 1'b0;
        else
            vk_reg <= vj_reg;
    end
    always_ff @(posedge clk)
    begin
        k_tw_reg <= utc_pkg::sat32(66'(j_tw_reg >>> FRAC_BITS));
        k_f_reg <= j_f_reg;
        k_vd_reg <= j_vd_reg;
        k_wd_reg <= j_wd_reg;
    end

    // stage L: wheel sums
    logic signed [31:0] l_sl_reg, l_sr_reg, l_vd_reg, l_wd_reg;
    logic               vl_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vl_reg <= 1'b0;
        else
            vl_reg <= vk_reg;
    end
    always_ff @(posedge clk)
    begin
        l_sl_reg <= utc_pkg::sat32(66'(k_f_reg) + 66'(k_tw_reg));
        l_sr_reg <= utc_pkg::sat32(66'(k_f_reg) - 66'(k_tw_reg));
        l_vd_reg <= k_vd_reg;
        l_wd_reg <= k_wd_reg;
    end

    // stage M: radius products
    logic signed [63:0] m_tl_reg, m_tr_reg;
    logic signed [31:0] m_vd_reg, m_wd_reg;
    logic               vm_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm_reg <= 1'b0;
        else
            vm_reg <= vl_reg;
    end
    always_ff @(posedge clk)
    begin
        m_tl_reg <= 64'(signed'({1'b0, g.wheel_radius})) * 64'(l_sl_reg);
        m_tr_reg <= 64'(signed'({1'b0, g.wheel_radius})) * 64'(l_sr_reg);
        m_vd_reg <= l_vd_reg;
        m_wd_reg <= l_wd_reg;
    end

    // stage N: output register
    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vm_reg;
    end
    always_ff @(posedge clk)
    begin
        left_torque <= utc_pkg::sat32(66'(m_tl_reg >>> (FRAC_BITS + 1)));
        right_torque <= utc_pkg::sat32(66'(m_tr_reg >>> (FRAC_BITS + 1)));
        desired_speed <= m_vd_reg;
        desired_turn_rate <= m_wd_reg;
    end
    assign done = done_reg;
endmodule
`default_nettype wire

### sv/utc_checker.sv
// Port-level checker for the tracking controller, bound to the top level.
// Depends on unicycle_tracking_controller ports only.
`timescale 1ns / 1ps
`default_nettype none
module utc_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire logic pready
);
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
    a_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(start, 66) && $past(rst_n, 66) |-> !done)
        else $error("done without transaction");
    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##66 done)
        else $error("missing result");
endmodule

bind unicycle_tracking_controller utc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .pready(pready)
);
`default_nettype wire
